// ----- rtl/vmd_pkg.sv -----
// Shared constants for the volume mask / masked-mean downsampler.
// No dependencies; every other file of the block but vmd_ram uses this package.
package vmd_pkg;

  localparam int DEF_MAX_SIZE    = 256;
  localparam int DEF_VALUE_WIDTH = 32;
  localparam int FIFO_DEPTH      = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int MASK_W     = 8;
  localparam int PORT_VAL_W = 32;
  localparam int CNT_W      = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

  // classification of one voxel, made by the front end
  typedef struct packed {
    logic first;
    logic emit;
    logic last;
  } vmd_ctl_t;

endpackage

// ----- rtl/volume_mask_and_masked_mean_downsample_core.sv -----
// Top level of the 2x2x2 mask max-pool and masked half-mean downsampler.
// Depends on vmd_pkg, vmd_front, vmd_fifo, vmd_back (and vmd_ram below it).
//
// Use:
//  - Write size_x/size_y/size_z (index 0..2) on the cfg channel while idle;
//    cfg_ready is always high and every size write restarts the volume.
//  - Push source voxels in raster order (x fastest) on in_*; a beat is taken
//    when in_push is high and in_full is low.
//  - One result per 2x2x2 cell appears on out_* while out_empty is low and
//    leaves on out_pop; out_last_voxel marks the final cell of a volume.
//  - The front end classifies a voxel in the cycle it is taken and parks it
//    in a two-entry queue; the back end pops it when idle and then does the
//    read-modify-write of the column partial memory.
//    A cell-closing voxel with a masked source then passes through the
//    bit-serial divider before the result register is loaded; a cell with
//    no masked source skips the divider.
//  - A stalled receiver holds the result register; the back end then waits
//    with the next result and the queue fills, raising in_full.
//  - Synchronous reset sets the sizes to 256 (clamped to MAX_SIZE) and the
//    position to the origin; the partial memory is not cleared, since each
//    entry is written by the first voxel of its cell.
module volume_mask_and_masked_mean_downsample_core #(
  parameter int MAX_SIZE    = vmd_pkg::DEF_MAX_SIZE,
  parameter int VALUE_WIDTH = vmd_pkg::DEF_VALUE_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vmd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vmd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [vmd_pkg::MASK_W-1:0]      in_voxel_mask,
  input  logic [vmd_pkg::PORT_VAL_W-1:0]  in_value_x,
  input  logic [vmd_pkg::PORT_VAL_W-1:0]  in_value_y,
  input  logic [vmd_pkg::PORT_VAL_W-1:0]  in_value_z,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [vmd_pkg::MASK_W-1:0]      out_mask_max,
  output logic [vmd_pkg::PORT_VAL_W-1:0]  out_mean_x,
  output logic [vmd_pkg::PORT_VAL_W-1:0]  out_mean_y,
  output logic [vmd_pkg::PORT_VAL_W-1:0]  out_mean_z,
  output logic                            out_no_constraint,
  output logic                            out_last_voxel
);
  import vmd_pkg::*;

  localparam int HALF = (MAX_SIZE + 1) / 2;
  localparam int AW   = (HALF * HALF > 1) ? $clog2(HALF * HALF) : 1;
  localparam int QW   = AW + $bits(vmd_ctl_t) + MASK_W + 3 * VALUE_WIDTH;

  logic                   f_push, f_full, b_pop, b_empty;
  logic [AW-1:0]          f_slot, b_slot;
  vmd_ctl_t               f_ctl, b_ctl;
  logic [MASK_W-1:0]      f_mask, b_mask;
  logic [VALUE_WIDTH-1:0] f_vx, f_vy, f_vz, b_vx, b_vy, b_vz;

  vmd_front #(.MAX_SIZE(MAX_SIZE), .VALUE_WIDTH(VALUE_WIDTH), .AW(AW)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cfg_ready     (cfg_ready),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_voxel_mask (in_voxel_mask),
    .in_value_x    (in_value_x),
    .in_value_y    (in_value_y),
    .in_value_z    (in_value_z),
    .q_push        (f_push),
    .q_full        (f_full),
    .q_slot        (f_slot),
    .q_ctl         (f_ctl),
    .q_mask        (f_mask),
    .q_vx          (f_vx),
    .q_vy          (f_vy),
    .q_vz          (f_vz)
  );

  vmd_fifo #(.WIDTH(QW), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata ({f_slot, f_ctl, f_mask, f_vx, f_vy, f_vz}),
    .full  (f_full),
    .pop   (b_pop),
    .rdata ({b_slot, b_ctl, b_mask, b_vx, b_vy, b_vz}),
    .empty (b_empty)
  );

  vmd_back #(.MAX_SIZE(MAX_SIZE), .VALUE_WIDTH(VALUE_WIDTH), .AW(AW)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (b_empty),
    .q_pop             (b_pop),
    .q_slot            (b_slot),
    .q_ctl             (b_ctl),
    .q_mask            (b_mask),
    .q_vx              (b_vx),
    .q_vy              (b_vy),
    .q_vz              (b_vz),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_mask_max      (out_mask_max),
    .out_mean_x        (out_mean_x),
    .out_mean_y        (out_mean_y),
    .out_mean_z        (out_mean_z),
    .out_no_constraint (out_no_constraint),
    .out_last_voxel    (out_last_voxel)
  );
endmodule

// ----- rtl/vmd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata_r
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end
endmodule

// ----- rtl/vmd_fifo.sv -----
// Short flop queue between the front end and the accumulator.
// Uses vmd_pkg only for the default depth.
module vmd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = vmd_pkg::FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, rptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end
endmodule

// ----- rtl/vmd_front.sv -----
// Front end: size registers, source position tracking and voxel classification.
// Depends on vmd_pkg; feeds vmd_fifo.
module vmd_front #(
  parameter int MAX_SIZE    = vmd_pkg::DEF_MAX_SIZE,
  parameter int VALUE_WIDTH = vmd_pkg::DEF_VALUE_WIDTH,
  parameter int AW          = 14
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [vmd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vmd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            cfg_ready,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [vmd_pkg::MASK_W-1:0]      in_voxel_mask,
  input  logic [vmd_pkg::PORT_VAL_W-1:0]  in_value_x,
  input  logic [vmd_pkg::PORT_VAL_W-1:0]  in_value_y,
  input  logic [vmd_pkg::PORT_VAL_W-1:0]  in_value_z,
  output logic                            q_push,
  input  logic                            q_full,
  output logic [AW-1:0]                   q_slot,
  output vmd_pkg::vmd_ctl_t               q_ctl,
  output logic [vmd_pkg::MASK_W-1:0]      q_mask,
  output logic [VALUE_WIDTH-1:0]          q_vx,
  output logic [VALUE_WIDTH-1:0]          q_vy,
  output logic [VALUE_WIDTH-1:0]          q_vz
);
  import vmd_pkg::*;

  localparam int SW     = $clog2(MAX_SIZE + 1);
  localparam int PW     = $clog2(MAX_SIZE);
  localparam int HALF   = (MAX_SIZE + 1) / 2;
  localparam int RST_SZ = (MAX_SIZE < 256) ? MAX_SIZE : 256;

  logic [SW-1:0] size_x_r, size_y_r, size_z_r;
  logic [PW-1:0] pos_x_r, pos_y_r, pos_z_r;
  logic [SW-1:0] clamped;
  logic [PW:0]   x1, y1, z1;
  logic          at_end_x, at_end_y, at_end_z;
  logic          accept, cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign in_full   = q_full;
  assign accept    = in_push && !q_full;
  assign q_push    = accept;

  always_comb begin
    if (cfg_data == '0) begin
      clamped = SW'(1);
    end else if (32'(cfg_data) > MAX_SIZE) begin
      clamped = SW'(MAX_SIZE);
    end else begin
      clamped = SW'(cfg_data);
    end
  end

  assign x1 = {1'b0, pos_x_r} + 1'b1;
  assign y1 = {1'b0, pos_y_r} + 1'b1;
  assign z1 = {1'b0, pos_z_r} + 1'b1;
  assign at_end_x = (32'(x1) >= 32'(size_x_r));
  assign at_end_y = (32'(y1) >= 32'(size_y_r));
  assign at_end_z = (32'(z1) >= 32'(size_z_r));

  assign q_slot = AW'(32'(pos_y_r >> 1) * HALF + 32'(pos_x_r >> 1));
  assign q_ctl.first = !pos_x_r[0] && !pos_y_r[0] && !pos_z_r[0];
  assign q_ctl.emit  = (pos_x_r[0] || at_end_x) && (pos_y_r[0] || at_end_y) &&
                       (pos_z_r[0] || at_end_z);
  assign q_ctl.last  = at_end_x && at_end_y && at_end_z;
  assign q_mask = in_voxel_mask;
  assign q_vx   = VALUE_WIDTH'({32'b0, in_value_x});
  assign q_vy   = VALUE_WIDTH'({32'b0, in_value_y});
  assign q_vz   = VALUE_WIDTH'({32'b0, in_value_z});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= SW'(RST_SZ);
      size_y_r <= SW'(RST_SZ);
      size_z_r <= SW'(RST_SZ);
      pos_x_r  <= '0;
      pos_y_r  <= '0;
      pos_z_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SIZE_X: size_x_r <= clamped;
        CFG_SIZE_Y: size_y_r <= clamped;
        CFG_SIZE_Z: size_z_r <= clamped;
        default: ;
      endcase
      // any size write restarts the volume
      if (cfg_index == CFG_SIZE_X || cfg_index == CFG_SIZE_Y ||
          cfg_index == CFG_SIZE_Z) begin
        pos_x_r <= '0;
        pos_y_r <= '0;
        pos_z_r <= '0;
      end
    end else if (accept) begin
      if (!at_end_x) begin
        pos_x_r <= PW'(x1);
      end else begin
        pos_x_r <= '0;
        if (!at_end_y) begin
          pos_y_r <= PW'(y1);
        end else begin
          pos_y_r <= '0;
          pos_z_r <= at_end_z ? '0 : PW'(z1);
        end
      end
    end
  end
endmodule

// ----- rtl/vmd_back.sv -----
// Back end: read-modify-write of the column partials, serial divider, result register.
// Depends on vmd_pkg and vmd_ram.
module vmd_back #(
  parameter int MAX_SIZE    = vmd_pkg::DEF_MAX_SIZE,
  parameter int VALUE_WIDTH = vmd_pkg::DEF_VALUE_WIDTH,
  parameter int AW          = 14
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  output logic                            q_pop,
  input  logic [AW-1:0]                   q_slot,
  input  vmd_pkg::vmd_ctl_t               q_ctl,
  input  logic [vmd_pkg::MASK_W-1:0]      q_mask,
  input  logic [VALUE_WIDTH-1:0]          q_vx,
  input  logic [VALUE_WIDTH-1:0]          q_vy,
  input  logic [VALUE_WIDTH-1:0]          q_vz,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [vmd_pkg::MASK_W-1:0]      out_mask_max,
  output logic [vmd_pkg::PORT_VAL_W-1:0]  out_mean_x,
  output logic [vmd_pkg::PORT_VAL_W-1:0]  out_mean_y,
  output logic [vmd_pkg::PORT_VAL_W-1:0]  out_mean_z,
  output logic                            out_no_constraint,
  output logic                            out_last_voxel
);
  import vmd_pkg::*;

  localparam int HALF  = (MAX_SIZE + 1) / 2;
  localparam int DEPTH = HALF * HALF;
  localparam int SUM_W = VALUE_WIDTH + 3;
  localparam int ENT_W = MASK_W + CNT_W + 3 * SUM_W;
  localparam int OW    = (VALUE_WIDTH < PORT_VAL_W) ? VALUE_WIDTH : PORT_VAL_W;
  localparam int DCW   = $clog2(SUM_W + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UPD  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [AW-1:0]          slot_r;
  vmd_ctl_t               ctl_r;
  logic [MASK_W-1:0]      mask_r;
  logic [VALUE_WIDTH-1:0] val_r [3];
  logic [ENT_W-1:0]       rdata, wdata;
  logic                   we;

  logic [MASK_W-1:0]      base_max, new_max;
  logic [CNT_W-1:0]       base_cnt, new_cnt;
  logic [SUM_W-1:0]       base_sum [3];
  logic [SUM_W-1:0]       new_sum [3];

  logic [CNT_W-1:0]       cnt_r;
  logic [MASK_W-1:0]      max_r;
  logic                   last_r;
  logic [SUM_W-1:0]       dq_r [3];
  logic [4:0]             rem_r [3];
  logic                   neg_r [3];
  logic [DCW-1:0]         step_r;
  logic [4:0]             divisor;
  logic [SUM_W-1:0]       signed_q [3];

  logic                   out_valid_r, out_free;

  vmd_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (slot_r),
    .wdata   (wdata),
    .raddr   (q_slot),
    .rdata_r (rdata)
  );

  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign we        = (state_r == S_UPD);
  assign out_free  = !out_valid_r || out_pop;
  assign out_empty = !out_valid_r;
  assign divisor   = {cnt_r, 1'b0};

  // a first voxel of its cell overrides whatever the entry held
  always_comb begin
    base_max = ctl_r.first ? '0 : rdata[ENT_W-1 -: MASK_W];
    base_cnt = ctl_r.first ? '0 : rdata[3*SUM_W +: CNT_W];
    for (int k = 0; k < 3; k++) begin
      base_sum[k] = ctl_r.first ? '0 : rdata[(2-k)*SUM_W +: SUM_W];
    end
    new_max = (mask_r > base_max) ? mask_r : base_max;
    new_cnt = (mask_r != '0) ? base_cnt + 1'b1 : base_cnt;
    for (int k = 0; k < 3; k++) begin
      new_sum[k] = (mask_r != '0) ?
                   base_sum[k] + {{3{val_r[k][VALUE_WIDTH-1]}}, val_r[k]} :
                   base_sum[k];
    end
    wdata = {new_max, new_cnt, new_sum[0], new_sum[1], new_sum[2]};
    for (int k = 0; k < 3; k++) begin
      signed_q[k] = neg_r[k] ? SUM_W'(0) - dq_r[k] : dq_r[k];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (!q_empty) state_nxt = S_UPD;
      S_UPD: begin
        if (!ctl_r.emit) begin
          state_nxt = S_IDLE;
        end else if (new_cnt == '0) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: if (step_r == DCW'(1)) state_nxt = S_OUT;
      S_OUT: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      slot_r   <= q_slot;
      ctl_r    <= q_ctl;
      mask_r   <= q_mask;
      val_r[0] <= q_vx;
      val_r[1] <= q_vy;
      val_r[2] <= q_vz;
    end
    if (state_r == S_UPD) begin
      cnt_r  <= new_cnt;
      max_r  <= new_max;
      last_r <= ctl_r.last;
      step_r <= DCW'(SUM_W);
      for (int k = 0; k < 3; k++) begin
        neg_r[k] <= new_sum[k][SUM_W-1];
        dq_r[k]  <= new_sum[k][SUM_W-1] ? SUM_W'(0) - new_sum[k] : new_sum[k];
        rem_r[k] <= '0;
      end
    end else if (state_r == S_DIV) begin
      // restoring division, one quotient bit per cycle on each lane
      step_r <= step_r - 1'b1;
      for (int k = 0; k < 3; k++) begin
        if ({rem_r[k], dq_r[k][SUM_W-1]} >= {1'b0, divisor}) begin
          rem_r[k] <= 5'({rem_r[k], dq_r[k][SUM_W-1]} - {1'b0, divisor});
          dq_r[k]  <= {dq_r[k][SUM_W-2:0], 1'b1};
        end else begin
          rem_r[k] <= 5'({rem_r[k], dq_r[k][SUM_W-1]});
          dq_r[k]  <= {dq_r[k][SUM_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_mask_max      <= max_r;
      out_no_constraint <= (cnt_r == '0);
      out_last_voxel    <= last_r;
      out_mean_x <= (cnt_r == '0) ? '0 : PORT_VAL_W'(signed_q[0][OW-1:0]);
      out_mean_y <= (cnt_r == '0) ? '0 : PORT_VAL_W'(signed_q[1][OW-1:0]);
      out_mean_z <= (cnt_r == '0) ? '0 : PORT_VAL_W'(signed_q[2][OW-1:0]);
    end
  end
endmodule

// ----- rtl/vmd_checker.sv -----
// Port-level checks for the downsampler top level, attached by bind.
// Depends on vmd_pkg for port widths.
module vmd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           cfg_ready,
  input logic                           in_full,
  input logic                           out_empty,
  input logic                           out_pop,
  input logic [vmd_pkg::MASK_W-1:0]     out_mask_max,
  input logic [vmd_pkg::PORT_VAL_W-1:0] out_mean_x,
  input logic [vmd_pkg::PORT_VAL_W-1:0] out_mean_y,
  input logic [vmd_pkg::PORT_VAL_W-1:0] out_mean_z,
  input logic                           out_no_constraint,
  input logic                           out_last_voxel
);
  // a waiting result holds until popped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_mean_x) &&
      $stable(out_mask_max) && $stable(out_last_voxel)))
    else $error("result changed while stalled");

  a_empty_mean: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_no_constraint) |->
      (out_mean_x == '0 && out_mean_y == '0 && out_mean_z == '0))
    else $error("empty cell with nonzero mean");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result pending after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("config port not ready");

  a_known_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({in_full, out_empty}))
    else $error("queue flags unknown");
endmodule

bind volume_mask_and_masked_mean_downsample_core vmd_checker u_vmd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .cfg_ready         (cfg_ready),
  .in_full           (in_full),
  .out_empty         (out_empty),
  .out_pop           (out_pop),
  .out_mask_max      (out_mask_max),
  .out_mean_x        (out_mean_x),
  .out_mean_y        (out_mean_y),
  .out_mean_z        (out_mean_z),
  .out_no_constraint (out_no_constraint),
  .out_last_voxel    (out_last_voxel)
);

// ----- test/volume_mask_and_masked_mean_downsample_core_tb.sv -----
// Testbench for the 2x2x2 mask max-pool and masked half-mean downsampler.
// Depends on vmd_pkg and the RTL top level; a scoreboard class predicts every cell.

class cell_scoreboard;
  typedef struct {
    logic [7:0]  mask_max;
    logic [31:0] mean_x;
    logic [31:0] mean_y;
    logic [31:0] mean_z;
    logic        no_constraint;
    logic        last_voxel;
  } cell_t;

  localparam int HALF = (vmd_pkg::DEF_MAX_SIZE + 1) / 2;

  int unsigned size_x, size_y, size_z;
  int unsigned pos_x, pos_y, pos_z;
  bit [7:0]    col_max[HALF*HALF];
  bit [3:0]    col_count[HALF*HALF];
  longint      col_sum_x[HALF*HALF];
  longint      col_sum_y[HALF*HALF];
  longint      col_sum_z[HALF*HALF];
  cell_t       pending_cells[$];
  int          errors;

  function new();
    size_x = vmd_pkg::DEF_MAX_SIZE;
    size_y = vmd_pkg::DEF_MAX_SIZE;
    size_z = vmd_pkg::DEF_MAX_SIZE;
    errors = 0;
  endfunction

  function void write_size(logic [1:0] index, logic [8:0] data);
    int unsigned v;
    v = data;
    if (v < 1) v = 1;
    if (v > vmd_pkg::DEF_MAX_SIZE) v = vmd_pkg::DEF_MAX_SIZE;
    case (index)
      vmd_pkg::CFG_SIZE_X: size_x = v;
      vmd_pkg::CFG_SIZE_Y: size_y = v;
      vmd_pkg::CFG_SIZE_Z: size_z = v;
      default: return;
    endcase
    pos_x = 0;
    pos_y = 0;
    pos_z = 0;
  endfunction

  function logic [31:0] half_mean(longint sum, int unsigned n);
    longint q;
    q = (n == 0) ? 0 : sum / longint'(2 * n);
    return q[31:0];
  endfunction

  function void note_voxel(logic [7:0] m, logic [31:0] vx, logic [31:0] vy,
                           logic [31:0] vz);
    int unsigned slot;
    cell_t c;
    bit end_x, end_y, end_z;
    slot = (pos_y >> 1) * HALF + (pos_x >> 1);
    if (!pos_x[0] && !pos_y[0] && !pos_z[0]) begin
      col_max[slot] = 0;
      col_count[slot] = 0;
      col_sum_x[slot] = 0;
      col_sum_y[slot] = 0;
      col_sum_z[slot] = 0;
    end
    if (m > col_max[slot]) col_max[slot] = m;
    if (m != 0) begin
      col_count[slot] = 4'(col_count[slot] + 1);
      col_sum_x[slot] += longint'(signed'(vx));
      col_sum_y[slot] += longint'(signed'(vy));
      col_sum_z[slot] += longint'(signed'(vz));
    end
    end_x = pos_x[0] || (pos_x + 1 >= size_x);
    end_y = pos_y[0] || (pos_y + 1 >= size_y);
    end_z = pos_z[0] || (pos_z + 1 >= size_z);
    if (end_x && end_y && end_z) begin
      c.mask_max = col_max[slot];
      c.mean_x = half_mean(col_sum_x[slot], col_count[slot]);
      c.mean_y = half_mean(col_sum_y[slot], col_count[slot]);
      c.mean_z = half_mean(col_sum_z[slot], col_count[slot]);
      c.no_constraint = (col_count[slot] == 0);
      c.last_voxel = (pos_x + 1 >= size_x) && (pos_y + 1 >= size_y) &&
                     (pos_z + 1 >= size_z);
      pending_cells.push_back(c);
    end
    // advance the raster position, wrapping at the end of the volume
    if (pos_x + 1 < size_x) begin
      pos_x++;
    end else begin
      pos_x = 0;
      if (pos_y + 1 < size_y) begin
        pos_y++;
      end else begin
        pos_y = 0;
        pos_z = (pos_z + 1 < size_z) ? pos_z + 1 : 0;
      end
    end
  endfunction

  function void check_cell(cell_t got);
    cell_t exp;
    if (pending_cells.size() == 0) begin
      $error("unexpected result beat: mask_max %0d", got.mask_max);
      errors++;
      return;
    end
    exp = pending_cells.pop_front();
    if (got.mask_max !== exp.mask_max) begin
      $error("mask_max: expected %0d, got %0d", exp.mask_max, got.mask_max);
      errors++;
    end
    if (got.mean_x !== exp.mean_x) begin
      $error("mean_x: expected %h, got %h", exp.mean_x, got.mean_x);
      errors++;
    end
    if (got.mean_y !== exp.mean_y) begin
      $error("mean_y: expected %h, got %h", exp.mean_y, got.mean_y);
      errors++;
    end
    if (got.mean_z !== exp.mean_z) begin
      $error("mean_z: expected %h, got %h", exp.mean_z, got.mean_z);
      errors++;
    end
    if (got.no_constraint !== exp.no_constraint) begin
      $error("no_constraint: expected %b, got %b", exp.no_constraint, got.no_constraint);
      errors++;
    end
    if (got.last_voxel !== exp.last_voxel) begin
      $error("last_voxel: expected %b, got %b", exp.last_voxel, got.last_voxel);
      errors++;
    end
  endfunction
endclass

module volume_mask_and_masked_mean_downsample_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int TARGET_VOXELS = 1850;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [8:0]  cfg_data;
  logic        in_push;
  logic        in_full;
  logic [7:0]  in_voxel_mask;
  logic [31:0] in_value_x, in_value_y, in_value_z;
  logic        out_empty;
  logic        out_pop;
  logic [7:0]  out_mask_max;
  logic [31:0] out_mean_x, out_mean_y, out_mean_z;
  logic        out_no_constraint;
  logic        out_last_voxel;

  cell_scoreboard cells = new();
  int  voxels_sent;
  int  pop_stall;
  int  cycle_count;
  bit  quiet;

  volume_mask_and_masked_mean_downsample_core DUT (.*);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [7:0] pick_mask();
    int r;
    r = $urandom_range(9);
    if (r < 3) return 8'd0;
    if (r == 3) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_voxel(logic [7:0] m, logic [31:0] vx, logic [31:0] vy,
                            logic [31:0] vz);
    int gap;
    in_voxel_mask <= m;
    in_value_x <= vx;
    in_value_y <= vy;
    in_value_z <= vz;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    cells.note_voxel(m, vx, vy, vz);
    voxels_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic push_random(int n);
    repeat (n) push_voxel(pick_mask(), pick_value(), pick_value(), pick_value());
  endtask

  // hold off until every cell is out and the back end has gone quiet
  task automatic wait_idle();
    in_push <= 1'b0;
    @(posedge clk);
    while (cells.pending_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leave cfg_valid high between back-to-back writes; the caller drops it
  task automatic write_reg(logic [1:0] index, logic [8:0] data);
    cfg_index <= index;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cells.write_size(index, data);
  endtask

  task automatic start_volume(logic [8:0] sx, logic [8:0] sy, logic [8:0] sz);
    wait_idle();
    write_reg(vmd_pkg::CFG_SIZE_X, sx);
    write_reg(vmd_pkg::CFG_SIZE_Y, sy);
    write_reg(vmd_pkg::CFG_SIZE_Z, sz);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty)
      cells.check_cell('{out_mask_max, out_mean_x, out_mean_y, out_mean_z,
                         out_no_constraint, out_last_voxel});
    if (pop_stall > 0) begin
      out_pop <= 1'b0;
      pop_stall <= pop_stall - 1;
    end else begin
      out_pop <= 1'b1;
      pop_stall <= pick_gap();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned sx, sy, sz, n;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_push = 1'b0;
    in_voxel_mask = '0;
    in_value_x = '0;
    in_value_y = '0;
    in_value_z = '0;
    out_pop = 1'b0;
    pop_stall = 0;
    cycle_count = 0;
    voxels_sent = 0;
    quiet = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full cells at the value extremes, two volumes back to back
    start_volume(9'd2, 9'd2, 9'd2);
    repeat (8) push_voxel(8'hFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    repeat (4) push_voxel(8'h01, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
    repeat (4) push_voxel(8'h00, 32'h1234_5678, 32'h8765_4321, 32'hFFFF_0000);
    // odd edges leave partial cells
    start_volume(9'd3, 9'd3, 9'd1);
    push_random(9);
    // zero sizes clamp to one; a lone unmasked voxel is an empty cell
    start_volume(9'd0, 9'd0, 9'd0);
    push_voxel(8'h00, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    // abandon a volume midway; the next size write restarts it and an oversized size clamps
    start_volume(9'd4, 9'd4, 9'd4);
    push_random(5);
    start_volume(9'd511, 9'd1, 9'd1);
    push_random(256);

    while (voxels_sent < TARGET_VOXELS) begin
      quiet = ($urandom_range(4) == 0);
      case ($urandom_range(11))
        0: begin sx = 256; sy = 2; sz = 1; end
        1: begin sx = 1; sy = 1; sz = 256; end
        2: begin sx = 1; sy = 256; sz = 1; end
        default: begin
          sx = $urandom_range(8, 1);
          sy = $urandom_range(8, 1);
          sz = $urandom_range(6, 1);
        end
      endcase
      start_volume(9'(sx), 9'(sy), 9'(sz));
      n = sx * sy * sz;
      if ($urandom_range(6) == 0) n = $urandom_range(n, 1);
      else if (n < 64 && $urandom_range(1)) n = 2 * n;
      push_random(n);
    end

    quiet = 1'b0;
    wait_idle();
    if (cells.errors == 0 && cells.pending_cells.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/vmd_pkg.sv
rtl/vmd_ram.sv
rtl/vmd_fifo.sv
rtl/vmd_front.sv
rtl/vmd_back.sv
rtl/volume_mask_and_masked_mean_downsample_core.sv
rtl/vmd_checker.sv
test/volume_mask_and_masked_mean_downsample_core_tb.sv
